### rtl/core/ecas_pkg.sv
`default_nettype none
package ecas_pkg;

  // Default side length of the stored grid.
  localparam int GridDimDefault = 64;

  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [15:0] AGE_MAX   = 16'hFFFF;
  localparam logic [31:0] LCG_MUL   = 32'd69069;
  localparam logic [31:0] LCG_ADD   = 32'd1;
  localparam logic [3:0]  LAST_SLOT = 4'd8;

  // Cell state codes.
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_SUSC  = 2'd1;
  localparam logic [1:0] ST_INF   = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_COMMIT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_GRID_SIZE   = 2'd0,
    REG_INFECT_PROB = 2'd1,
    REG_DEATH_RATE  = 2'd2,
    REG_BIRTH_RATE  = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_WRITE,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_AGE_MUL,
    S_POW,
    S_DECIDE,
    S_COPY,
    S_DRAIN,
    S_FIN
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       wr_cell;
    logic       rd_issue;
    logic [3:0] rd_slot;
    logic       age_mul;
    logic       pow_step;
    logic       decide;
    logic       copy_start;
    logic       copy_step;
    logic       out_load;
  } ecas_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e       cmd;
    logic       in_store;
    logic       in_grid;
    logic [3:0] nb_count;
    logic       copy_last;
  } ecas_sts_t;

  // Probabilities above one are taken as one.
  function automatic logic [16:0] sat_prob(input logic [16:0] p);
    return (p > ONE_Q16) ? ONE_Q16 : p;
  endfunction

  // Row offset of a read slot: slot 0 is the cell itself, 1 to 8 the Moore neighbours.
  function automatic logic signed [7:0] nb_dx(input logic [3:0] slot);
    logic signed [7:0] d;
    case (slot)
      4'd1, 4'd2, 4'd3: d = -8'sd1;
      4'd6, 4'd7, 4'd8: d = 8'sd1;
      default:          d = 8'sd0;
    endcase
    return d;
  endfunction

  // Column offset of a read slot.
  function automatic logic signed [7:0] nb_dy(input logic [3:0] slot);
    logic signed [7:0] d;
    case (slot)
      4'd1, 4'd4, 4'd6: d = -8'sd1;
      4'd3, 4'd5, 4'd8: d = 8'sd1;
      default:          d = 8'sd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

### rtl/core/ecas_datapath.sv
`default_nettype none
module ecas_datapath #(
  parameter int GRID_DIM = ecas_pkg::GridDimDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [1:0]        command_i,
  input  wire logic [5:0]        x_coord_i,
  input  wire logic [5:0]        y_coord_i,
  input  wire logic [1:0]        cell_state_i,
  input  wire logic [15:0]       cell_age_i,
  input  wire logic [31:0]       random_word_i,
  input  wire logic [6:0]        grid_size_i,
  input  wire logic [16:0]       infect_prob_i,
  input  wire logic [16:0]       death_rate_i,
  input  wire logic [16:0]       birth_rate_i,
  input  wire ecas_pkg::ecas_cmd_t cmd_i,
  output ecas_pkg::ecas_sts_t    sts_o,
  output logic [1:0]             out_state_o,
  output logic [15:0]            out_age_o,
  output logic [12:0]            infected_count_o
);
  import ecas_pkg::*;

  localparam int CELLS = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(CELLS);

  // Latched word.
  cmd_e        cmd_q;
  logic [5:0]  x_q, y_q;
  logic [1:0]  wst_q;
  logic [15:0] wage_q;
  logic [31:0] u_q;

  // Grid banks.
  logic [17:0] cur_mem [CELLS];
  logic [17:0] nxt_mem [CELLS];
  logic [17:0] cur_rd_q, nxt_rd_q;

  logic [17:0] cen_q;
  logic [3:0]  slot_q, n_q;
  logic        slot_ok_q, rd_pend_q;
  logic [16:0] r_q;
  logic [31:0] prod_q;
  logic [1:0]  upd_st_q;
  logic [15:0] upd_age_q;
  logic [12:0] tally_q, cnt_q;
  logic [AW-1:0] copy_cnt_q, copy_waddr_q;
  logic        copy_pend_q;

  logic        in_store, in_grid;
  logic signed [7:0] nx, ny;
  logic        nb_ok, slot_ok;
  logic [AW-1:0] addr_c, addr_s;
  logic [1:0]  cst, tgt;
  logic [15:0] cage;
  logic [16:0] mul_a, mul_b, prob_sel;
  logic [33:0] prod;
  logic [15:0] uh;
  logic        hit, gate, dies, tally_inc;
  logic [1:0]  new_st, wst_fix;
  logic [15:0] new_age, age_inc;

  assign in_store = (32'(x_q) < GRID_DIM) && (32'(y_q) < GRID_DIM);
  assign in_grid  = in_store && ({1'b0, x_q} < grid_size_i) && ({1'b0, y_q} < grid_size_i);
  assign wst_fix  = (wst_q == 2'd3) ? ST_EMPTY : wst_q;

  // Address of the cell itself and of the slot being read.
  assign nx = $signed({2'b00, x_q}) + nb_dx(cmd_i.rd_slot);
  assign ny = $signed({2'b00, y_q}) + nb_dy(cmd_i.rd_slot);
  assign nb_ok = !nx[7] && !ny[7] && (nx[6:0] < grid_size_i) && (ny[6:0] < grid_size_i)
                 && (32'(nx[6:0]) < GRID_DIM) && (32'(ny[6:0]) < GRID_DIM);
  assign slot_ok = (cmd_i.rd_slot == 4'd0) ? in_store : nb_ok;
  assign addr_c  = AW'(32'(x_q) * GRID_DIM + 32'(y_q));
  assign addr_s  = AW'(32'(nx[6:0]) * GRID_DIM + 32'(ny[6:0]));

  assign cst  = cen_q[17:16];
  assign cage = cen_q[15:0];
  assign tgt  = (cst == ST_EMPTY) ? ST_SUSC : ST_INF;

  // Shared multiplier: age times rate, or one step of the power.
  assign prob_sel = (cst == ST_EMPTY) ? sat_prob(birth_rate_i) : sat_prob(infect_prob_i);
  always_comb begin
    if (cmd_i.age_mul) begin
      mul_a = {1'b0, cage};
      mul_b = (cst == ST_INF) ? sat_prob(death_rate_i) : sat_prob(birth_rate_i);
    end else begin
      mul_a = r_q;
      mul_b = ONE_Q16 - prob_sel;
    end
  end
  assign prod = mul_a * mul_b;

  // Outcome of an update.
  assign uh      = u_q[31:16];
  assign hit     = {1'b0, uh} < (ONE_Q16 - r_q);
  assign gate    = prod_q >= 32'h10000;
  assign dies    = {16'b0, uh} < prod_q;
  always_comb begin
    new_st    = cst;
    new_age   = cage;
    tally_inc = 1'b0;
    case (cst)
      ST_EMPTY: begin
        if (gate && hit) begin
          new_st  = ST_SUSC;
          new_age = '0;
        end
      end
      ST_SUSC: begin
        if (hit) begin
          new_st    = ST_INF;
          new_age   = '0;
          tally_inc = 1'b1;
        end
      end
      ST_INF: begin
        tally_inc = 1'b1;
        if (dies) begin
          new_st  = ST_EMPTY;
          new_age = '0;
        end
      end
      default: new_st = ST_EMPTY;
    endcase
  end
  assign age_inc = (new_age == AGE_MAX) ? new_age : new_age + 16'd1;

  // Word capture and scrambling of the random value.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= cmd_e'(command_i);
      x_q    <= x_coord_i;
      y_q    <= y_coord_i;
      wst_q  <= cell_state_i;
      wage_q <= cell_age_i;
      u_q    <= 32'(random_word_i * LCG_MUL + LCG_ADD);
    end
  end

  // Current bank: cell writes and copy writes, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_cell && in_store) begin
      cur_mem[addr_c] <= {wst_fix, wage_q};
    end else if (copy_pend_q) begin
      cur_mem[copy_waddr_q] <= nxt_rd_q;
    end
    if (cmd_i.rd_issue && slot_ok) begin
      cur_rd_q <= cur_mem[addr_s];
    end
  end

  // Next bank: cell writes and update results, read by the commit copy.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_cell && in_store) begin
      nxt_mem[addr_c] <= {wst_fix, wage_q};
    end else if (cmd_i.decide) begin
      nxt_mem[addr_c] <= {new_st, age_inc};
    end
    if (cmd_i.copy_step) begin
      nxt_rd_q <= nxt_mem[copy_cnt_q];
    end
  end

  // Read tracking, neighbour count and working values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      copy_pend_q <= 1'b0;
      tally_q     <= '0;
      slot_q      <= '0;
      slot_ok_q   <= 1'b0;
      n_q         <= '0;
      copy_cnt_q  <= '0;
    end else begin
      rd_pend_q   <= cmd_i.rd_issue;
      slot_q      <= cmd_i.rd_slot;
      slot_ok_q   <= slot_ok;
      copy_pend_q <= cmd_i.copy_step;
      if (cmd_i.load) begin
        n_q <= '0;
      end else if (rd_pend_q && slot_q != 4'd0 && slot_ok_q && cur_rd_q[17:16] == tgt) begin
        n_q <= n_q + 4'd1;
      end
      if (cmd_i.copy_start) begin
        tally_q    <= '0;
        copy_cnt_q <= '0;
      end else begin
        if (cmd_i.decide && tally_inc && tally_q != '1) begin
          tally_q <= tally_q + 13'd1;
        end
        if (cmd_i.copy_step) begin
          copy_cnt_q <= copy_cnt_q + AW'(1);
        end
      end
    end
  end

  // Payload registers of the update and commit.
  always_ff @(posedge clk_i) begin
    if (rd_pend_q && slot_q == 4'd0) begin
      cen_q <= cur_rd_q;
    end
    if (cmd_i.load) begin
      r_q <= ONE_Q16;
    end else if (cmd_i.pow_step) begin
      r_q <= 17'(prod >> 16);
    end
    if (cmd_i.age_mul) begin
      prod_q <= 32'(prod);
    end
    if (cmd_i.decide) begin
      upd_st_q  <= new_st;
      upd_age_q <= age_inc;
    end
    if (cmd_i.copy_start) begin
      cnt_q <= tally_q;
    end
    if (cmd_i.copy_step) begin
      copy_waddr_q <= copy_cnt_q;
    end
  end

  // Result word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_state_o      <= '0;
      out_age_o        <= '0;
      infected_count_o <= '0;
      case (cmd_q)
        CMD_WRITE: begin
          if (in_store) begin
            out_state_o <= wst_fix;
            out_age_o   <= wage_q;
          end
        end
        CMD_READ: begin
          if (in_store) begin
            out_state_o <= cst;
            out_age_o   <= cage;
          end
        end
        CMD_UPDATE: begin
          if (in_grid) begin
            out_state_o <= upd_st_q;
            out_age_o   <= upd_age_q;
          end
        end
        default: infected_count_o <= cnt_q;
      endcase
    end
  end

  assign sts_o.cmd       = cmd_q;
  assign sts_o.in_store  = in_store;
  assign sts_o.in_grid   = in_grid;
  assign sts_o.nb_count  = n_q;
  assign sts_o.copy_last = (copy_cnt_q == AW'(CELLS - 1));

endmodule
`default_nettype wire

### rtl/core/ecas_ctrl.sv
`default_nettype none
module ecas_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                out_stall_i,
  input  wire ecas_pkg::ecas_sts_t sts_i,
  output ecas_pkg::ecas_cmd_t      cmd_o,
  output logic                     in_stall_o,
  output logic                     out_valid_o
);
  import ecas_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [3:0]  slot_q, pow_cnt_q;
  logic        out_valid_q;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISP;
      end
      S_DISP: begin
        unique case (sts_i.cmd)
          CMD_WRITE:  state_d = S_WRITE;
          CMD_READ:   state_d = sts_i.in_store ? S_RD_ISSUE : S_FIN;
          CMD_UPDATE: state_d = sts_i.in_grid ? S_RD_ISSUE : S_FIN;
          default:    state_d = S_COPY;
        endcase
      end
      S_WRITE: state_d = S_FIN;
      S_RD_ISSUE: begin
        if (sts_i.cmd == CMD_READ || slot_q == LAST_SLOT) state_d = S_RD_WAIT;
      end
      S_RD_WAIT: state_d = (sts_i.cmd == CMD_READ) ? S_FIN : S_AGE_MUL;
      S_AGE_MUL: state_d = S_POW;
      S_POW: begin
        if (pow_cnt_q == sts_i.nb_count) state_d = S_DECIDE;
      end
      S_DECIDE: state_d = S_FIN;
      S_COPY: begin
        if (sts_i.copy_last) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_FIN;
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o         = '0;
    cmd_o.rd_slot = slot_q;
    unique case (state_q)
      S_IDLE:     cmd_o.load       = in_valid_i;
      S_DISP:     cmd_o.copy_start = (sts_i.cmd == CMD_COMMIT);
      S_WRITE:    cmd_o.wr_cell    = 1'b1;
      S_RD_ISSUE: cmd_o.rd_issue   = 1'b1;
      S_AGE_MUL:  cmd_o.age_mul    = 1'b1;
      S_POW:      cmd_o.pow_step   = (pow_cnt_q != sts_i.nb_count);
      S_DECIDE:   cmd_o.decide     = 1'b1;
      S_COPY:     cmd_o.copy_step  = 1'b1;
      S_FIN:      cmd_o.out_load   = out_free;
      default:    cmd_o.load       = 1'b0;
    endcase
  end

  // State, counters and the result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      pow_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DISP) begin
        slot_q <= '0;
      end else if (state_q == S_RD_ISSUE) begin
        slot_q <= slot_q + 4'd1;
      end
      if (state_q == S_AGE_MUL) begin
        pow_cnt_q <= '0;
      end else if (cmd_o.pow_step) begin
        pow_cnt_q <= pow_cnt_q + 4'd1;
      end
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

### rtl/core/epidemic_cellular_automaton_step.sv
`default_nettype none
// Stochastic cellular automaton of empty, susceptible and infected cells over a
// GRID_DIM by GRID_DIM grid held in two banks, driven one command word at a time
// with exactly one result word per command. An update makes nine reads through the
// single read port of the current bank, then one age pass and n power passes through
// the shared 17 by 17 multiplier, n being the number of relevant neighbours (0 to 8).
// A commit copies the next bank into the current one, one cell a cycle. A finished
// result waits in the output register while the next command word is accepted.
module epidemic_cellular_automaton_step #(
  parameter int GRID_DIM = ecas_pkg::GridDimDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [5:0]  x_coord_i,
  input  wire logic [5:0]  y_coord_i,
  input  wire logic [1:0]  cell_state_i,
  input  wire logic [15:0] cell_age_i,
  input  wire logic [31:0] random_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       out_state_o,
  output logic [15:0]      out_age_o,
  output logic [12:0]      infected_count_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ecas_pkg::*;

  logic [6:0]  grid_size_q;
  logic [16:0] infect_prob_q, death_rate_q, birth_rate_q;
  reg_idx_e    reg_idx;
  ecas_cmd_t   cmd;
  ecas_sts_t   sts;

  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q   <= 7'd50;
      infect_prob_q <= 17'd6554;
      death_rate_q  <= 17'd32768;
      birth_rate_q  <= 17'd32768;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_GRID_SIZE:   grid_size_q   <= pwdata[6:0];
        REG_INFECT_PROB: infect_prob_q <= pwdata[16:0];
        REG_DEATH_RATE:  death_rate_q  <= pwdata[16:0];
        default:         birth_rate_q  <= pwdata[16:0];
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_GRID_SIZE:   prdata = {25'b0, grid_size_q};
      REG_INFECT_PROB: prdata = {15'b0, infect_prob_q};
      REG_DEATH_RATE:  prdata = {15'b0, death_rate_q};
      default:         prdata = {15'b0, birth_rate_q};
    endcase
  end

  ecas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  ecas_datapath #(
    .GRID_DIM (GRID_DIM)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .command_i        (command_i),
    .x_coord_i        (x_coord_i),
    .y_coord_i        (y_coord_i),
    .cell_state_i     (cell_state_i),
    .cell_age_i       (cell_age_i),
    .random_word_i    (random_word_i),
    .grid_size_i      (grid_size_q),
    .infect_prob_i    (infect_prob_q),
    .death_rate_i     (death_rate_q),
    .birth_rate_i     (birth_rate_q),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_state_o      (out_state_o),
    .out_age_o        (out_age_o),
    .infected_count_o (infected_count_o)
  );

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import ecas_pkg::*;

  localparam int Dim = 64;
  localparam int Cells = Dim * Dim;
  localparam int CycleLimit = 1500000;
  localparam int HoldCycles = 400;

  typedef struct packed {
    cmd_e        cmd;
    logic [5:0]  x;
    logic [5:0]  y;
    logic [1:0]  st;
    logic [15:0] age;
    logic [31:0] rw;
  } word_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [15:0] age;
    logic [12:0] cnt;
  } cell_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = '0;
  logic [5:0]  x_coord_i = '0;
  logic [5:0]  y_coord_i = '0;
  logic [1:0]  cell_state_i = '0;
  logic [15:0] cell_age_i = '0;
  logic [31:0] random_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  out_state_o;
  logic [15:0] out_age_o;
  logic [12:0] infected_count_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  epidemic_cellular_automaton_step DUT (.*);

  // Clock generation.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  word_t       pending_words[$];
  cell_res_t   expected_results[$];
  int          errors = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_req = 1'b0;
  int          hold_left = 0;
  int          cycles = 0;

  // Predictor state: both banks, the tally and the register copies.
  logic [17:0] cur_bank[Cells];
  logic [17:0] nxt_bank[Cells];
  logic [12:0] tally;
  logic [6:0]  p_size;
  logic [16:0] p_infect, p_death, p_birth;

  // Generator's view of which entries have been written in each bank.
  bit          cur_ok[Cells];
  bit          nxt_ok[Cells];
  int          gen_size;

  function automatic logic [16:0] clip_q16(logic [16:0] p);
    return (p > 17'h10000) ? 17'h10000 : p;
  endfunction

  // Threshold 1-(1-p)^n, scaled to compare against the 32-bit scrambled word.
  function automatic longint unsigned spread_odds(logic [16:0] p, int n);
    longint unsigned q, r;
    q = 65536 - clip_q16(p);
    r = 65536;
    for (int i = 0; i < n; i++) r = (r * q) >> 16;
    return (65536 - r) << 16;
  endfunction

  function automatic int count_nbrs(logic [1:0] st, int x, int y, int sz);
    int n;
    n = 0;
    for (int dx = -1; dx <= 1; dx++)
      for (int dy = -1; dy <= 1; dy++) begin
        if ((dx != 0 || dy != 0) && x + dx >= 0 && y + dy >= 0 &&
            x + dx < sz && y + dy < sz && cur_bank[(x + dx) * Dim + y + dy][17:16] == st)
          n++;
      end
    return n;
  endfunction

  // Work out the result of one accepted word and advance the predictor state.
  function automatic cell_res_t epidemic_next(word_t w);
    cell_res_t       r;
    int              sz, x, y;
    longint unsigned u;
    logic [1:0]      st;
    logic [15:0]     age;
    logic [1:0]      wst;
    r = '0;
    x = w.x;
    y = w.y;
    sz = (p_size > Dim) ? Dim : p_size;
    u = 64'(32'(w.rw * 32'd69069 + 32'd1));
    case (w.cmd)
      CMD_WRITE: begin
        wst = (w.st == 2'd3) ? ST_EMPTY : w.st;
        cur_bank[x * Dim + y] = {wst, w.age};
        nxt_bank[x * Dim + y] = {wst, w.age};
        r.st = wst;
        r.age = w.age;
      end
      CMD_READ: begin
        r.st = cur_bank[x * Dim + y][17:16];
        r.age = cur_bank[x * Dim + y][15:0];
      end
      CMD_UPDATE: begin
        if (x < sz && y < sz) begin
          st = cur_bank[x * Dim + y][17:16];
          age = cur_bank[x * Dim + y][15:0];
          if (st == ST_EMPTY) begin
            if (64'(age) * clip_q16(p_birth) >= 65536 &&
                u < spread_odds(p_birth, count_nbrs(ST_SUSC, x, y, sz))) begin
              st = ST_SUSC;
              age = 0;
            end
          end else if (st == ST_SUSC) begin
            if (u < spread_odds(p_infect, count_nbrs(ST_INF, x, y, sz))) begin
              st = ST_INF;
              age = 0;
              if (tally != 13'h1FFF) tally++;
            end
          end else if (st == ST_INF) begin
            if (u < ((64'(age) * clip_q16(p_death)) << 16)) begin
              st = ST_EMPTY;
              age = 0;
            end
            if (tally != 13'h1FFF) tally++;
          end else begin
            st = ST_EMPTY;
          end
          if (age != 16'hFFFF) age++;
          nxt_bank[x * Dim + y] = {st, age};
          r.st = st;
          r.age = age;
        end
      end
      default: begin
        cur_bank = nxt_bank;
        r.cnt = tally;
        tally = '0;
      end
    endcase
    return r;
  endfunction

  // An update may only touch written entries: the cell and its in-grid neighbours.
  function automatic bit update_legal(int x, int y);
    if (x >= gen_size || y >= gen_size) return 1'b1;
    for (int dx = -1; dx <= 1; dx++)
      for (int dy = -1; dy <= 1; dy++)
        if (x + dx >= 0 && y + dy >= 0 && x + dx < gen_size && y + dy < gen_size &&
            !cur_ok[(x + dx) * Dim + y + dy])
          return 1'b0;
    return 1'b1;
  endfunction

  task automatic queue_word(cmd_e c, int x, int y, logic [1:0] st, logic [15:0] age,
                            logic [31:0] rw);
    word_t w;
    w = '{cmd: c, x: x[5:0], y: y[5:0], st: st, age: age, rw: rw};
    if (c == CMD_WRITE) begin
      cur_ok[x * Dim + y] = 1'b1;
      nxt_ok[x * Dim + y] = 1'b1;
    end else if (c == CMD_UPDATE && x < gen_size && y < gen_size) begin
      nxt_ok[x * Dim + y] = 1'b1;
    end else if (c == CMD_COMMIT) begin
      cur_ok = nxt_ok;
    end
    pending_words.push_back(w);
  endtask

  function automatic logic [15:0] pick_age();
    case ($urandom_range(0, 3))
      0, 1: return 16'($urandom_range(0, 4));
      2: return 16'($urandom);
      default: return 16'($urandom_range(65533, 65535));
    endcase
  endfunction

  // A random stream of words, mostly inside a small written window of the grid.
  task automatic queue_random(int count);
    int w, ox, x, y, k;
    w = (gen_size < 6) ? gen_size : 6;
    ox = ($urandom_range(0, 1) != 0) ? gen_size - w : 0;
    for (int i = 0; i < w; i++)
      for (int j = 0; j < w; j++)
        queue_word(CMD_WRITE, ox + i, ox + j, 2'($urandom_range(0, 3)), pick_age(),
                   $urandom);
    for (int n = 0; n < count; n++) begin
      if (w > 0 && $urandom_range(0, 9) < 8) begin
        x = ox + $urandom_range(0, w - 1);
        y = ox + $urandom_range(0, w - 1);
      end else begin
        x = $urandom_range(0, Dim - 1);
        y = $urandom_range(0, Dim - 1);
      end
      k = $urandom_range(0, 99);
      if (k < 2)
        queue_word(CMD_COMMIT, x, y, 2'($urandom), 16'($urandom), $urandom);
      else if (k < 17 && cur_ok[x * Dim + y])
        queue_word(CMD_READ, x, y, 2'($urandom), 16'($urandom), $urandom);
      else if (k >= 40 && update_legal(x, y))
        queue_word(CMD_UPDATE, x, y, 2'($urandom), 16'($urandom), $urandom);
      else
        queue_word(CMD_WRITE, x, y, 2'($urandom_range(0, 3)), pick_age(), $urandom);
    end
  endtask

  // Register write over the configuration port: setup then access cycle.
  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GRID_SIZE: begin
        p_size = val[6:0];
        gen_size = (val[6:0] > Dim) ? Dim : val[6:0];
      end
      REG_INFECT_PROB: p_infect = val[16:0];
      REG_DEATH_RATE: p_death = val[16:0];
      default: p_birth = val[16:0];
    endcase
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Word driver: presents the next pending word unless idling.
  always @(posedge clk_i) begin
    if (!in_valid_i || !in_stall_o) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        word_t w;
        w = pending_words.pop_front();
        in_valid_i <= 1'b1;
        command_i <= w.cmd;
        x_coord_i <= w.x;
        y_coord_i <= w.y;
        cell_state_i <= w.st;
        cell_age_i <= w.age;
        random_word_i <= w.rw;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall, with a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor: predict on each accepted word, check each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        expected_results.push_back(epidemic_next('{cmd: cmd_e'(command_i), x: x_coord_i,
          y: y_coord_i, st: cell_state_i, age: cell_age_i, rw: random_word_i}));
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result state %0d age %0d count %0d", $time,
                   out_state_o, out_age_o, infected_count_o);
        end else begin
          cell_res_t e;
          e = expected_results.pop_front();
          if (out_state_o !== e.st) begin
            errors++;
            $display("%0t: out_state expected %0d got %0d", $time, e.st, out_state_o);
          end
          if (out_age_o !== e.age) begin
            errors++;
            $display("%0t: out_age expected %0d got %0d", $time, e.age, out_age_o);
          end
          if (infected_count_o !== e.cnt) begin
            errors++;
            $display("%0t: infected_count expected %0d got %0d", $time, e.cnt,
                     infected_count_o);
          end
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** epidemic_cellular_automaton_step: FAILED **");
      $finish;
    end
  end

  initial begin
    int sizes[8] = '{4, 1, 64, 0, 100, 7, 3, 5};
    int infects[8] = '{65536, 0, 30000, 131071, 6554, 50000, 65535, 20000};
    int deaths[8] = '{0, 65536, 131071, 1000, 32768, 65535, 200, 40000};
    int births[8] = '{65536, 131071, 0, 20000, 32768, 1, 65535, 50000};
    tally = '0;
    p_size = 7'd50;
    p_infect = 17'd6554;
    p_death = 17'd32768;
    p_birth = 17'd32768;
    gen_size = 50;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words with the reset configuration.
    queue_word(CMD_WRITE, 63, 63, 2'd3, 16'hFFFF, 32'h0);
    queue_word(CMD_READ, 63, 63, 2'd0, 16'd0, 32'h0);
    queue_word(CMD_WRITE, 0, 0, ST_INF, 16'hFFFF, 32'h0);
    queue_word(CMD_WRITE, 0, 1, ST_SUSC, 16'd0, 32'h0);
    queue_word(CMD_WRITE, 1, 0, ST_EMPTY, 16'd5, 32'h0);
    queue_word(CMD_WRITE, 1, 1, ST_INF, 16'd1, 32'h0);
    queue_word(CMD_UPDATE, 0, 0, 2'd0, 16'd0, 32'hFFFFFFFF);
    queue_word(CMD_UPDATE, 0, 1, 2'd0, 16'd0, 32'h0);
    queue_word(CMD_UPDATE, 1, 0, 2'd0, 16'd0, 32'h12345678);
    queue_word(CMD_UPDATE, 1, 1, 2'd0, 16'd0, 32'hFFFFFFFF);
    queue_word(CMD_UPDATE, 50, 3, 2'd0, 16'd0, 32'h0);
    queue_word(CMD_UPDATE, 63, 63, 2'd0, 16'd0, 32'h0);
    queue_word(CMD_COMMIT, 0, 0, 2'd0, 16'd0, 32'h0);
    queue_word(CMD_READ, 0, 0, 2'd0, 16'd0, 32'h0);
    queue_word(CMD_READ, 1, 1, 2'd0, 16'd0, 32'h0);
    queue_word(CMD_COMMIT, 0, 0, 2'd0, 16'd0, 32'h0);
    wait_drained();

    // Phases over several configurations and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_GRID_SIZE, sizes[ph]);
      write_reg(REG_INFECT_PROB, infects[ph]);
      write_reg(REG_DEATH_RATE, deaths[ph]);
      write_reg(REG_BIRTH_RATE, births[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      queue_random(200);
      if (ph == 4) begin
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
      wait_drained();
    end

    if (errors == 0)
      $display("** epidemic_cellular_automaton_step: PASSED **");
    else
      $display("** epidemic_cellular_automaton_step: FAILED **");
    $finish;
  end

endmodule

### sim.f
rtl/core/ecas_pkg.sv
rtl/core/ecas_datapath.sv
rtl/core/ecas_ctrl.sv
rtl/core/epidemic_cellular_automaton_step.sv
tb/tb_top.sv
